[rtl/core/rme_pkg.sv]
// ----------------------------------------------------------------------------
// rme_pkg
// Shared types, constants and helpers for the register machine execute core.
// ----------------------------------------------------------------------------
package rme_pkg;

    localparam int NUM_REGS   = 6;
    localparam int WORD_WIDTH = 32;
    localparam int CFG_IDX_W  = 1;

    typedef logic [WORD_WIDTH-1:0] t_word;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IP_REGISTER = 1'b0,
        CFG_START_VALUE = 1'b1
    } t_cfg_index;

    typedef enum logic [3:0] {
        FN_ADDR = 4'd0,
        FN_ADDI = 4'd1,
        FN_MULR = 4'd2,
        FN_MULI = 4'd3,
        FN_BANR = 4'd4,
        FN_BANI = 4'd5,
        FN_BORR = 4'd6,
        FN_BORI = 4'd7,
        FN_SETR = 4'd8,
        FN_SETI = 4'd9,
        FN_GTIR = 4'd10,
        FN_GTRI = 4'd11,
        FN_GTRR = 4'd12,
        FN_EQIR = 4'd13,
        FN_EQRI = 4'd14,
        FN_EQRR = 4'd15
    } t_func;

    typedef struct packed {
        logic [3:0]         func;
        logic signed [31:0] operand_a;
        logic signed [31:0] operand_b;
        logic [2:0]         dest_index;
        logic               restart;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] next_ip;
        logic signed [31:0] reg_zero;
        logic signed [31:0] reg_one;
        logic signed [31:0] reg_two;
        logic signed [31:0] reg_three;
        logic signed [31:0] reg_four;
        logic signed [31:0] reg_five;
        logic               fault;
    } t_out_item;

    // Sign-extend (or truncate) a 32-bit field to the machine word.
    function automatic t_word sext32(input logic [31:0] v);
        logic [63:0] wide;
        wide = {{32{v[31]}}, v};
        return wide[WORD_WIDTH-1:0];
    endfunction

    // Low 32 bits of a machine word, zero-filled when the word is narrower.
    function automatic logic [31:0] low32(input t_word w);
        logic [63:0] wide;
        wide = 64'(w);
        return wide[31:0];
    endfunction

    function automatic logic a_is_reg(input t_func f);
        logic r;
        case (f)
            FN_SETI, FN_GTIR, FN_EQIR: r = 1'b0;
            default:                   r = 1'b1;
        endcase
        return r;
    endfunction

    function automatic logic b_is_reg(input t_func f);
        logic r;
        case (f)
            FN_ADDR, FN_MULR, FN_BANR, FN_BORR,
            FN_GTIR, FN_GTRR, FN_EQIR, FN_EQRR: r = 1'b1;
            default:                            r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

[rtl/core/rme_alu.sv]
// ----------------------------------------------------------------------------
// rme_alu
// Opcode evaluation on two selected operands: add, multiply, logic, set and
// signed compares.
// ----------------------------------------------------------------------------
module rme_alu import rme_pkg::*; (
    input  t_func i_func,
    input  t_word i_a,
    input  t_word i_b,
    output t_word o_res
);

    logic w_gt;
    logic w_eq;

    assign w_gt = $signed(i_a) > $signed(i_b);
    assign w_eq = (i_a == i_b);

    always_comb begin
        case (i_func)
            FN_ADDR, FN_ADDI:          o_res = i_a + i_b;
            FN_MULR, FN_MULI:          o_res = i_a * i_b;
            FN_BANR, FN_BANI:          o_res = i_a & i_b;
            FN_BORR, FN_BORI:          o_res = i_a | i_b;
            FN_SETR, FN_SETI:          o_res = i_a;
            FN_GTIR, FN_GTRI, FN_GTRR: o_res = {{(WORD_WIDTH-1){1'b0}}, w_gt};
            FN_EQIR, FN_EQRI, FN_EQRR: o_res = {{(WORD_WIDTH-1){1'b0}}, w_eq};
            default:                   o_res = '0;
        endcase
    end

endmodule

[rtl/core/register_machine_execute_core.sv]
// ----------------------------------------------------------------------------
// register_machine_execute_core
// Datapath: a transaction accepted into the input register moves into the
// result register when it advances; an output stall keeps it waiting.
// Throughput: one instruction per cycle unless the output stalls; register
// file and pointer update as an instruction enters the result register.
// Reset: synchronous, active low; clears registers, pointer and configuration.
// ----------------------------------------------------------------------------
module register_machine_execute_core import rme_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_item             i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data
);

    logic        r_in_valid;
    t_in_item    r_in;
    logic        r_out_valid;
    t_out_item   r_out;
    t_word       r_regs [NUM_REGS];
    t_word       r_ip;
    logic [2:0]  r_ip_register;
    logic [31:0] r_start_value;

    t_word       n_regs [NUM_REGS];
    t_word       n_ip;
    t_out_item   n_out;

    logic        w_advance;
    logic        w_in_take;
    t_func       w_func;
    logic        w_bound;
    t_word       w_ip_base;
    t_word       w_regs_rs [NUM_REGS];
    t_word       w_reg_a;
    t_word       w_reg_b;
    t_word       w_a;
    t_word       w_b;
    t_word       w_res;
    logic        w_a_bad;
    logic        w_b_bad;
    logic        w_fault;
    t_word       w_bound_val;
    logic [31:0] w_out_regs [6];

    assign w_advance   = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !w_advance;
    assign w_in_take   = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;
    assign w_func      = t_func'(r_in.func);
    assign w_bound     = 32'(r_ip_register) < 32'(NUM_REGS);

    // Restart, then copy the pointer into the bound register.
    always_comb begin
        w_ip_base = r_in.restart ? '0 : r_ip;
        for (int i = 0; i < NUM_REGS; i++) begin
            if (r_in.restart) begin
                w_regs_rs[i] = (i == 0) ? sext32(r_start_value) : '0;
            end else begin
                w_regs_rs[i] = r_regs[i];
            end
            if (w_bound && 32'(r_ip_register) == 32'(i)) begin
                w_regs_rs[i] = w_ip_base;
            end
        end
    end

    // Operand fetch; an out-of-range index reads as zero.
    always_comb begin
        w_reg_a = '0;
        w_reg_b = '0;
        for (int i = 0; i < NUM_REGS; i++) begin
            if ($unsigned(r_in.operand_a) == 32'(i)) begin
                w_reg_a = w_regs_rs[i];
            end
            if ($unsigned(r_in.operand_b) == 32'(i)) begin
                w_reg_b = w_regs_rs[i];
            end
        end
        w_a_bad = a_is_reg(w_func) && !($unsigned(r_in.operand_a) < 32'(NUM_REGS));
        w_b_bad = b_is_reg(w_func) && !($unsigned(r_in.operand_b) < 32'(NUM_REGS));
        w_a     = a_is_reg(w_func) ? w_reg_a : sext32(r_in.operand_a);
        w_b     = b_is_reg(w_func) ? w_reg_b : sext32(r_in.operand_b);
    end

    rme_alu u_alu (
        .i_func (w_func),
        .i_a    (w_a),
        .i_b    (w_b),
        .o_res  (w_res)
    );

    // Write back, advance the pointer and assemble the result transaction.
    always_comb begin
        w_fault = !w_bound || w_a_bad || w_b_bad
                  || !(32'(r_in.dest_index) < 32'(NUM_REGS));
        w_bound_val = '0;
        for (int i = 0; i < NUM_REGS; i++) begin
            n_regs[i] = w_regs_rs[i];
            if (!w_fault && 32'(r_in.dest_index) == 32'(i)) begin
                n_regs[i] = w_res;
            end
            if (32'(r_ip_register) == 32'(i)) begin
                w_bound_val = n_regs[i];
            end
        end
        n_ip = w_bound ? w_bound_val + t_word'(1) : w_ip_base + t_word'(1);

        for (int k = 0; k < 6; k++) begin
            w_out_regs[k] = '0;
            for (int j = 0; j < NUM_REGS; j++) begin
                if (j == k) begin
                    w_out_regs[k] = low32(n_regs[j]);
                end
            end
        end
        n_out.next_ip   = low32(n_ip);
        n_out.reg_zero  = w_out_regs[0];
        n_out.reg_one   = w_out_regs[1];
        n_out.reg_two   = w_out_regs[2];
        n_out.reg_three = w_out_regs[3];
        n_out.reg_four  = w_out_regs[4];
        n_out.reg_five  = w_out_regs[5];
        n_out.fault     = w_fault;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_ip          <= '0;
            r_ip_register <= '0;
            r_start_value <= '0;
            for (int i = 0; i < NUM_REGS; i++) begin
                r_regs[i] <= '0;
            end
        end else begin
            if (w_in_take) begin
                r_in_valid <= 1'b1;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end

            if (w_advance) begin
                r_out_valid <= 1'b1;
                r_ip        <= n_ip;
                for (int i = 0; i < NUM_REGS; i++) begin
                    r_regs[i] <= n_regs[i];
                end
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg_valid && o_cfg_ready) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_IP_REGISTER: r_ip_register <= i_cfg_data[2:0];
                    CFG_START_VALUE: r_start_value <= i_cfg_data;
                    default:         ;
                endcase
            end
        end
    end

    // Payload registers: hold while stalled.
    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in <= i_in_data;
        end
        if (w_advance) begin
            r_out <= n_out;
        end
    end

`ifndef SYNTHESIS
    a_advance_fills_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |=> r_out_valid)
        else $error("result register not loaded after advance");

    a_ip_matches_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |=> (r_out.next_ip == low32(r_ip)))
        else $error("reported pointer differs from architectural pointer");

    a_unbound_faults: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && !w_bound) |=> r_out.fault)
        else $error("unbound pointer register did not raise fault");
`endif

endmodule
